FILE: design/qspi_pkg.sv
// Package for the quadrature speed PI controller: command and register
// codes, widths and the speed limit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qspi_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_TARGET = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_GAIN_CURRENT  = 1'b0;
  localparam logic CFG_GAIN_PREVIOUS = 1'b1;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int LANES    = 4;
  localparam int COUNT_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int TARGET_W = 9;
  localparam int ERR_W    = 8;
  localparam int GAIN_W   = 16;
  localparam int DRIVE_W  = 9;

  // Speed saturation limit and the width that holds +-SPEED_LIMIT.
  localparam int SPEED_LIMIT = 255;
  localparam int SPEED_W     = $clog2(SPEED_LIMIT + 1) + 1;

  // Width of the accumulated speed update before saturation.
  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int SUM_W  = ((SPEED_W > PROD_W) ? SPEED_W : PROD_W) + 3;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // Low bits of a speed, sign extended first when the speed is narrow.
  function automatic logic signed [DRIVE_W-1:0] to_drive(input speed_t s);
    logic signed [SPEED_W+DRIVE_W-1:0] ext;
    ext = (SPEED_W + DRIVE_W)'(s);
    return ext[DRIVE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/qspi_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on qspi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qspi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [qspi_pkg::CMD_W-1:0]           cmd;
  logic [qspi_pkg::LANES-1:0]           a_levels;
  logic [qspi_pkg::LANES-1:0]           b_levels;
  logic [qspi_pkg::BYTE_W-1:0]          left_target_byte;
  logic [qspi_pkg::BYTE_W-1:0]          right_target_byte;

  modport source (output valid, cmd, a_levels, b_levels, left_target_byte,
                  right_target_byte, input ready);
  modport sink   (input valid, cmd, a_levels, b_levels, left_target_byte,
                  right_target_byte, output ready);
endinterface

interface qspi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qspi_pkg::DRIVE_W-1:0]  left_drive;
  logic signed [qspi_pkg::DRIVE_W-1:0]  right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

`default_nettype wire

FILE: design/qspi_side.sv
// Per-side PI arithmetic: error from target and two encoder counts, then
// the velocity-form speed update with saturation. Depends on qspi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qspi_side (
  input  wire logic signed [qspi_pkg::TARGET_W-1:0] target,
  input  wire qspi_pkg::count_t                     count1,
  input  wire qspi_pkg::count_t                     count2,
  input  wire qspi_pkg::speed_t                     speed,
  input  wire qspi_pkg::err_t                       prev_err,
  input  wire logic signed [qspi_pkg::GAIN_W-1:0]   gain_cur,
  input  wire logic signed [qspi_pkg::GAIN_W-1:0]   gain_prev,
  output qspi_pkg::err_t                            err,
  output qspi_pkg::speed_t                          speed_nxt
);

  localparam int DIFF_W = qspi_pkg::TARGET_W + 2;
  localparam logic signed [DIFF_W-1:0] ERR_MAX = DIFF_W'(127);
  localparam logic signed [DIFF_W-1:0] ERR_MIN = -DIFF_W'(128);
  localparam logic signed [qspi_pkg::SUM_W-1:0] LIM_POS =
    qspi_pkg::SUM_W'(qspi_pkg::SPEED_LIMIT);
  localparam logic signed [qspi_pkg::SUM_W-1:0] LIM_NEG = -LIM_POS;

  logic signed [DIFF_W-1:0]               diff;
  logic signed [DIFF_W-1:0]               half;
  logic signed [qspi_pkg::PROD_W-1:0]     prod_cur;
  logic signed [qspi_pkg::PROD_W-1:0]     prod_prev;
  logic signed [qspi_pkg::SUM_W-1:0]      acc;

  // Twice the target minus the count sum, halved toward zero.
  always_comb begin
    diff = (DIFF_W'(target) <<< 1)
         - DIFF_W'($signed(count1)) - DIFF_W'($signed(count2));
    half = (diff >>> 1) + $signed(DIFF_W'(diff[DIFF_W-1] & diff[0]));
    if (half > ERR_MAX) begin
      err = qspi_pkg::ERR_W'(ERR_MAX);
    end else if (half < ERR_MIN) begin
      err = qspi_pkg::ERR_W'(ERR_MIN);
    end else begin
      err = qspi_pkg::ERR_W'(half);
    end
  end

  // Speed plus both gain terms, clamped to the speed limit.
  always_comb begin
    prod_cur  = qspi_pkg::PROD_W'(gain_cur) * qspi_pkg::PROD_W'(err);
    prod_prev = qspi_pkg::PROD_W'(gain_prev) * qspi_pkg::PROD_W'(prev_err);
    acc = qspi_pkg::SUM_W'(speed) + qspi_pkg::SUM_W'(prod_cur)
        + qspi_pkg::SUM_W'(prod_prev);
    if (acc > LIM_POS) begin
      speed_nxt = qspi_pkg::SPEED_W'(LIM_POS);
    end else if (acc < LIM_NEG) begin
      speed_nxt = qspi_pkg::SPEED_W'(LIM_NEG);
    end else begin
      speed_nxt = qspi_pkg::SPEED_W'(acc);
    end
  end

endmodule

`default_nettype wire

FILE: design/quadrature_speed_pi_controller_top.sv
// Top level of the quadrature speed PI controller: input stage, encoder
// counters, control state and result register. Uses qspi_pkg, qspi_if, qspi_side.
// An accepted word is held in the input register, and its results then go to
// the result register.
// Throughput: one word per cycle; the input stage and the result register
// advance together whenever the result register is empty or being taken.
// Reset (synchronous, rst_n low): gains, counts, targets, errors and speeds
// go to zero, the A history to all ones, and both channels are emptied.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_speed_pi_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  qspi_in_if.sink                            in_ch,
  qspi_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [qspi_pkg::GAIN_W-1:0]   cfg_data
);

  // Configuration registers.
  logic signed [qspi_pkg::GAIN_W-1:0] gain_cur_r;
  logic signed [qspi_pkg::GAIN_W-1:0] gain_prev_r;

  // Input stage.
  logic                               s1_valid_r;
  logic [qspi_pkg::CMD_W-1:0]         s1_cmd_r;
  logic [qspi_pkg::LANES-1:0]         s1_a_r;
  logic [qspi_pkg::LANES-1:0]         s1_b_r;
  logic [qspi_pkg::BYTE_W-1:0]        s1_lt_r;
  logic [qspi_pkg::BYTE_W-1:0]        s1_rt_r;

  // Control state.
  logic [qspi_pkg::LANES-1:0]         a_hist_r;
  qspi_pkg::count_t                   count_r [qspi_pkg::LANES];
  qspi_pkg::count_t                   count_nxt [qspi_pkg::LANES];
  qspi_pkg::target_t                  tgt_left_r;
  qspi_pkg::target_t                  tgt_right_r;
  qspi_pkg::err_t                     err_left_r;
  qspi_pkg::err_t                     err_right_r;
  qspi_pkg::speed_t                   speed_left_r;
  qspi_pkg::speed_t                   speed_right_r;
  qspi_pkg::speed_t                   speed_left_nxt;
  qspi_pkg::speed_t                   speed_right_nxt;

  // Result register.
  logic                               out_valid_r;
  logic signed [qspi_pkg::DRIVE_W-1:0] out_left_r;
  logic signed [qspi_pkg::DRIVE_W-1:0] out_right_r;

  logic                               advance;
  logic                               do_sample;
  logic                               do_tick;
  logic                               do_target;
  qspi_pkg::err_t                     err_left;
  qspi_pkg::err_t                     err_right;
  qspi_pkg::speed_t                   upd_left;
  qspi_pkg::speed_t                   upd_right;

  // Handshake: the stage moves when the result register can take a word.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.left_drive  = out_left_r;
  assign out_ch.right_drive = out_right_r;

  assign do_sample = advance && (s1_cmd_r == qspi_pkg::CMD_SAMPLE);
  assign do_tick   = advance && (s1_cmd_r == qspi_pkg::CMD_TICK);
  assign do_target = advance && (s1_cmd_r == qspi_pkg::CMD_TARGET);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_cur_r  <= '0;
      gain_prev_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qspi_pkg::CFG_GAIN_CURRENT:  gain_cur_r  <= cfg_data;
        qspi_pkg::CFG_GAIN_PREVIOUS: gain_prev_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_r <= in_ch.cmd;
      s1_a_r   <= in_ch.a_levels;
      s1_b_r   <= in_ch.b_levels;
      s1_lt_r  <= in_ch.left_target_byte;
      s1_rt_r  <= in_ch.right_target_byte;
    end
  end

  // Encoder counters: a changed A level steps its count by the A xor B sense.
  always_comb begin
    for (int i = 0; i < qspi_pkg::LANES; i++) begin
      if (do_tick) begin
        count_nxt[i] = '0;
      end else if (do_sample && (s1_a_r[i] ^ a_hist_r[i])) begin
        if (s1_a_r[i] ^ s1_b_r[i]) begin
          count_nxt[i] = count_r[i] + qspi_pkg::COUNT_W'(1);
        end else begin
          count_nxt[i] = count_r[i] - qspi_pkg::COUNT_W'(1);
        end
      end else begin
        count_nxt[i] = count_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_hist_r <= '1;
      for (int i = 0; i < qspi_pkg::LANES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (do_sample) begin
        a_hist_r <= s1_a_r;
      end
      for (int i = 0; i < qspi_pkg::LANES; i++) begin
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // PI update for each side.
  qspi_side u_side_left (
    .target    (tgt_left_r),
    .count1    (count_r[0]),
    .count2    (count_r[1]),
    .speed     (speed_left_r),
    .prev_err  (err_left_r),
    .gain_cur  (gain_cur_r),
    .gain_prev (gain_prev_r),
    .err       (err_left),
    .speed_nxt (upd_left)
  );

  qspi_side u_side_right (
    .target    (tgt_right_r),
    .count1    (count_r[2]),
    .count2    (count_r[3]),
    .speed     (speed_right_r),
    .prev_err  (err_right_r),
    .gain_cur  (gain_cur_r),
    .gain_prev (gain_prev_r),
    .err       (err_right),
    .speed_nxt (upd_right)
  );

  assign speed_left_nxt  = do_tick ? upd_left  : speed_left_r;
  assign speed_right_nxt = do_tick ? upd_right : speed_right_r;

  // Targets, previous errors and speeds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_left_r    <= '0;
      tgt_right_r   <= '0;
      err_left_r    <= '0;
      err_right_r   <= '0;
      speed_left_r  <= '0;
      speed_right_r <= '0;
    end else begin
      if (do_target) begin
        tgt_left_r  <= -qspi_pkg::TARGET_W'($signed(s1_lt_r));
        tgt_right_r <= qspi_pkg::TARGET_W'($signed(s1_rt_r));
      end
      if (do_tick) begin
        err_left_r  <= err_left;
        err_right_r <= err_right;
      end
      speed_left_r  <= speed_left_nxt;
      speed_right_r <= speed_right_nxt;
    end
  end

  // Result register: speeds after the word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left_r  <= qspi_pkg::to_drive(speed_left_nxt);
      out_right_r <= qspi_pkg::to_drive(speed_right_nxt);
    end
  end

  // A tick leaves all four counts cleared.
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_tick |=> (count_r[0] == '0) && (count_r[1] == '0)
             && (count_r[2] == '0) && (count_r[3] == '0))
    else $error("counts not cleared after tick");

  // A sample word becomes the new A history.
  a_hist_follows: assert property (@(posedge clk) disable iff (!rst_n)
    do_sample |=> a_hist_r == $past(s1_a_r))
    else $error("A history not updated by sample");

  // Speeds stay within the limit.
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_left_r <= qspi_pkg::SPEED_W'(qspi_pkg::SPEED_LIMIT))
    && (speed_left_r >= -qspi_pkg::SPEED_W'(qspi_pkg::SPEED_LIMIT))
    && (speed_right_r <= qspi_pkg::SPEED_W'(qspi_pkg::SPEED_LIMIT))
    && (speed_right_r >= -qspi_pkg::SPEED_W'(qspi_pkg::SPEED_LIMIT)))
    else $error("speed beyond limit");

  // Speeds change only on a tick.
  a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !do_tick |=> $stable(speed_left_r) && $stable(speed_right_r))
    else $error("speed changed without tick");

  // A stalled result register keeps the stage from moving.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("stage advanced into a full result register");

endmodule

`default_nettype wire
